>>> design/mhc_pkg.sv
// Package for the masked histogram counter unit.
// Holds the payload structs, command and operation codes and table sizes.
// No dependencies.
package mhc_pkg;

  localparam int MAX_BINS  = 256;
  localparam int BIN_AW    = $clog2(MAX_BINS);
  localparam int BIN_CNT_W = 9;
  localparam int COUNT_W   = 32;

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [BIN_CNT_W-1:0] BIN_LIMIT = BIN_CNT_W'(MAX_BINS);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sample;
    logic        mask_bit;
    logic [7:0]  bin_index;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic        dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_COUNT,
    OP_DROP,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef struct packed {
    logic               en;
    logic [BIN_AW-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } wr_req_t;

endpackage

>>> design/mhc_bin_mem.sv
// Bin count memory with one registered read port and one write port.
// Per-entry valid bits mark never-written bins after reset, so mhc_update reads them as zero.
// Depends on mhc_pkg.
module mhc_bin_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [mhc_pkg::BIN_AW-1:0]   rd_addr,
  input  mhc_pkg::wr_req_t             wr,
  output logic [mhc_pkg::COUNT_W-1:0]  rd_data,
  output logic                         rd_vld
);

  logic [mhc_pkg::COUNT_W-1:0] mem [mhc_pkg::MAX_BINS];
  logic [mhc_pkg::MAX_BINS-1:0] valid_r;
  logic [mhc_pkg::COUNT_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

>>> design/mhc_update.sv
// Read-modify-write stage and output register of the histogram unit.
// Forwards the previous write when it hits the bin just read.
// Depends on mhc_pkg.
module mhc_update (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  mhc_pkg::op_t                 acc_op,
  input  logic [mhc_pkg::BIN_AW-1:0]   acc_addr,
  input  logic [mhc_pkg::COUNT_W-1:0]  acc_wval,
  input  logic [mhc_pkg::COUNT_W-1:0]  rd_data,
  input  logic                         rd_vld,
  input  logic                         out_ready,
  output logic                         in_ready,
  output mhc_pkg::wr_req_t             wr,
  output logic                         out_valid,
  output mhc_pkg::out_item_t           out_data
);

  logic                        s1_v_r;
  mhc_pkg::op_t                s1_op_r;
  logic [mhc_pkg::BIN_AW-1:0]  s1_addr_r;
  logic [mhc_pkg::COUNT_W-1:0] s1_wval_r;
  logic                        fwd_v_r;
  logic [mhc_pkg::COUNT_W-1:0] fwd_data_r;
  logic                        out_v_r;
  mhc_pkg::out_item_t          out_data_r;

  logic                        s1_go;
  logic [mhc_pkg::COUNT_W-1:0] old_cnt;
  logic                        wr_need;
  logic [mhc_pkg::COUNT_W-1:0] wr_val;
  mhc_pkg::out_item_t          res;

  assign s1_go    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;
  assign old_cnt  = fwd_v_r ? fwd_data_r : (rd_vld ? rd_data : '0);

  always_comb begin
    wr_need     = 1'b0;
    wr_val      = old_cnt + mhc_pkg::COUNT_W'(1);
    res.count   = '0;
    res.dropped = 1'b0;
    case (s1_op_r)
      mhc_pkg::OP_COUNT: begin
        wr_need   = 1'b1;
        res.count = wr_val;
      end
      mhc_pkg::OP_DROP: begin
        res.dropped = 1'b1;
      end
      mhc_pkg::OP_READ: begin
        res.count = old_cnt;
      end
      mhc_pkg::OP_WRITE: begin
        wr_need   = 1'b1;
        wr_val    = s1_wval_r;
        res.count = s1_wval_r;
      end
      default: begin
        res.count = '0;
      end
    endcase
  end

  assign wr.en   = s1_go && wr_need;
  assign wr.addr = s1_addr_r;
  assign wr.data = wr_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r  <= 1'b1;
        fwd_v_r <= wr.en && (wr.addr == acc_addr);
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r    <= acc_op;
      s1_addr_r  <= acc_addr;
      s1_wval_r  <= acc_wval;
      fwd_data_r <= wr.data;
    end
    if (s1_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

>>> design/masked_histogram_counter_unit.sv
// Top level of the masked histogram counter unit.
// Instantiates mhc_bin_mem and mhc_update; depends on mhc_pkg.
//
// Usage:
//   Items arrive on the in_ channel (valid/ready) as one struct: cmd selects
//   counting a sample, reading a bin or writing a bin. Every transfer in
//   produces exactly one transfer out on the out_ channel with the bin count
//   and a dropped flag for masked or out-of-range samples.
//   cfg_we with cfg_wdata sets the number of bins in use; write it only while
//   the unit is idle. Samples at or above that number are dropped.
// Pipeline and throughput:
//   Results are registered in the update stage and then the output register.
//   One item is taken per cycle unless out_ready stalls the output, set by the
//   single read-modify-write pass over the bin memory; a write to the bin read
//   in the same cycle is forwarded, so repeated bins do not slow the stream.
// Reset and stalls:
//   Synchronous reset clears all bins through per-bin valid bits and sets
//   the bin count to 256; no clearing pass is needed. When the receiver
//   holds out_ready low, one result waits in the output register, one item
//   waits in the update stage, and in_ready then drops.
module masked_histogram_counter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mhc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mhc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mhc_pkg::BIN_CNT_W-1:0]       cfg_wdata
);

  logic [mhc_pkg::BIN_CNT_W-1:0] bin_count_r;
  logic [mhc_pkg::BIN_CNT_W-1:0] limit;
  logic                          acc;
  logic                          in_range;
  mhc_pkg::op_t                  acc_op;
  logic [mhc_pkg::BIN_AW-1:0]    acc_addr;
  logic [mhc_pkg::COUNT_W-1:0]   rd_data;
  logic                          rd_vld;
  mhc_pkg::wr_req_t              wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= mhc_pkg::BIN_LIMIT;
    end else if (cfg_we) begin
      bin_count_r <= cfg_wdata;
    end
  end

  assign limit    = (bin_count_r > mhc_pkg::BIN_LIMIT) ? mhc_pkg::BIN_LIMIT : bin_count_r;
  assign acc      = in_valid && in_ready;
  assign in_range = (in_data.sample[63:mhc_pkg::BIN_CNT_W] == '0) &&
                    (in_data.sample[mhc_pkg::BIN_CNT_W-1:0] < limit);

  always_comb begin
    acc_addr = in_data.bin_index[mhc_pkg::BIN_AW-1:0];
    case (in_data.cmd)
      mhc_pkg::CMD_COUNT: begin
        acc_op   = (in_data.mask_bit && in_range) ? mhc_pkg::OP_COUNT : mhc_pkg::OP_DROP;
        acc_addr = in_data.sample[mhc_pkg::BIN_AW-1:0];
      end
      mhc_pkg::CMD_READ:  acc_op = mhc_pkg::OP_READ;
      mhc_pkg::CMD_WRITE: acc_op = mhc_pkg::OP_WRITE;
      default:            acc_op = mhc_pkg::OP_NOP;
    endcase
  end

  mhc_bin_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (acc_addr),
    .wr      (wr),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  mhc_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .acc_op    (acc_op),
    .acc_addr  (acc_addr),
    .acc_wval  (in_data.write_value),
    .rd_data   (rd_data),
    .rd_vld    (rd_vld),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .wr        (wr),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sim/histogram_checker.sv
`timescale 1ns / 1ps
// Checker for the masked histogram counter unit: it keeps its own bin table,
// predicts the result of every input transfer and compares the output transfers.
// Depends on mhc_pkg.
module histogram_checker
  import mhc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [BIN_CNT_W-1:0] cfg_wdata,
  output int                   error_count,
  output int                   pending_results
);

  localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RESET = 9'd256;

  logic [COUNT_W-1:0]   bin_table [MAX_BINS];
  logic [BIN_CNT_W-1:0] bins_in_use;
  out_item_t            expected_results [$];

  initial begin
    error_count = 0;
    pending_results = 0;
  end

  // Applies one item to the local bin table and returns the result it causes.
  function automatic out_item_t histogram_result(input in_item_t item);
    out_item_t   res;
    logic [63:0] limit;
    res = '0;
    limit = (bins_in_use > BIN_LIMIT) ? 64'(MAX_BINS) : 64'(bins_in_use);
    case (item.cmd)
      CMD_COUNT: begin
        if (item.mask_bit && item.sample < limit) begin
          bin_table[item.sample[BIN_AW-1:0]] += 1;
          res.count = bin_table[item.sample[BIN_AW-1:0]];
        end else begin
          res.dropped = 1'b1;
        end
      end
      CMD_READ: res.count = bin_table[item.bin_index];
      CMD_WRITE: begin
        bin_table[item.bin_index] = item.write_value;
        res.count = item.write_value;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (error_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int b = 0; b < MAX_BINS; b++) begin
        bin_table[b] = '0;
      end
      bins_in_use = BIN_COUNT_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected output transfer: count %h dropped %b",
                                 out_data.count, out_data.dropped));
        end else begin
          want = expected_results.pop_front();
          if (want.count !== out_data.count || want.dropped !== out_data.dropped) begin
            note_failure($sformatf("mismatch: count exp %h got %h, dropped exp %b got %b",
                                   want.count, out_data.count, want.dropped,
                                   out_data.dropped));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(histogram_result(in_data));
      end
      if (cfg_we) begin
        bins_in_use = cfg_wdata;
      end
    end
    pending_results = expected_results.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for masked_histogram_counter_unit: drives directed and
// random sample, read and write transfers with random idling on both sides.
// Depends on mhc_pkg, the unit itself and histogram_checker.
module testbench;
  import mhc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int LONG_STALL_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 110;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [BIN_CNT_W-1:0] cfg_wdata = '0;

  int          error_count;
  int          pending_results;
  int          idle_pct = 0;
  bit          long_stall_req = 1'b0;
  int unsigned cycle_count = 0;

  masked_histogram_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  histogram_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(12, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [63:0] sample,
                                         input logic mask_bit, input logic [7:0] bin_index,
                                         input logic [31:0] write_value);
    in_item_t it;
    it.cmd = cmd;
    it.sample = sample;
    it.mask_bit = mask_bit;
    it.bin_index = bin_index;
    it.write_value = write_value;
    return it;
  endfunction

  // Half of the samples fall on eight hot bins so that counts build up and repeat
  // back to back; the rest spread around the limit or over all 64 bits.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.sample = {$urandom(), $urandom()};
    it.mask_bit = ($urandom_range(99) < 85);
    it.bin_index = 8'($urandom_range(255));
    it.write_value = $urandom();
    pick = $urandom_range(99);
    if (pick < 62) begin
      it.cmd = CMD_COUNT;
    end else if (pick < 80) begin
      it.cmd = CMD_READ;
    end else if (pick < 95) begin
      it.cmd = CMD_WRITE;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.sample = 64'($urandom_range(7));
    end else if (pick < 80) begin
      it.sample = 64'($urandom_range(260));
    end
    if ($urandom_range(1) == 0) begin
      it.bin_index = 8'($urandom_range(7));
    end
    if ($urandom_range(9) < 3) begin
      it.write_value = 32'hFFFF_FFFF - $urandom_range(3);
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bin_count(input logic [BIN_CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_side
    int gap;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase_bins [9];
    phase_bins = '{256, 0, 511, 1, 2, 300, 255, 37, 0};
    phase_bins[8] = $urandom_range(511);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transfers at the reset bin count, sent back to back.
    idle_pct = 0;
    send_item(make_item(CMD_COUNT, 64'd0, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_COUNT, 64'd255, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_COUNT, 64'd256, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(CMD_COUNT, 64'h8000_0000_0000_0000, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_COUNT, 64'h1_0000_0003, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_COUNT, 64'd3, 1'b0, 8'd0, 32'd0));
    repeat (3) send_item(make_item(CMD_COUNT, 64'd3, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_WRITE, 64'd0, 1'b0, 8'd0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_COUNT, 64'd0, 1'b1, 8'd0, 32'd0));
    send_item(make_item(CMD_READ, 64'd0, 1'b0, 8'd0, 32'd0));
    send_item(make_item(CMD_WRITE, 64'd0, 1'b0, 8'd255, 32'h5A5A_A5A5));
    send_item(make_item(CMD_READ, 64'd0, 1'b0, 8'd255, 32'd0));
    send_item(make_item(CMD_READ, 64'd0, 1'b0, 8'd128, 32'd0));
    send_item(make_item(CMD_WRITE, 64'd0, 1'b0, 8'd7, 32'd0));
    send_item(make_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(CMD_READ, 64'd0, 1'b0, 8'd3, 32'd0));
    send_item(make_item(CMD_WRITE, 64'd0, 1'b0, 8'd3, 32'h7FFF_FFFF));
    send_item(make_item(CMD_COUNT, 64'd3, 1'b1, 8'd0, 32'd0));
    drain_results();

    for (int p = 0; p < 9; p++) begin
      set_bin_count(phase_bins[p][BIN_CNT_W-1:0]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ((p == 2 || p == 6) && i == 40) begin
          long_stall_req = 1'b1;
        end
        send_item(random_item());
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mhc_pkg.sv
design/mhc_bin_mem.sv
design/mhc_update.sv
design/masked_histogram_counter_unit.sv
sim/histogram_checker.sv
sim/testbench.sv
